### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

### hdl/rbsd_pkg.sv
// ----------------------------------------------------------------------------
// rbsd_pkg
// Types and constants shared by the run-length byte stream decoder.
// ----------------------------------------------------------------------------
package rbsd_pkg;

    localparam int LANES_DEF      = 8;
    localparam int COUNT_BITS_DEF = 16;
    localparam int OUT_LANES      = 8;
    localparam int MAX_CHUNKS     = 16;
    localparam int CHUNK_W        = 4;
    localparam int RUN_W          = 7;
    localparam int LIMIT_W        = 16;
    localparam int MODE_W         = 2;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    localparam logic [7:0] RUN_BASE = 8'd128;

    localparam logic [MODE_W-1:0] MODE_PASS   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REPEAT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ZERO   = 2'd2;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_VALUE   = 2'd2
    } t_phase;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RUN  = 1'b1
    } t_state;

    typedef struct packed {
        logic accept;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic run_req;
        logic run_done;
        logic out_free;
    } t_dp_sts;

    typedef logic [OUT_LANES-1:0][7:0] t_lanes;

endpackage

### hdl/rbsd_ctrl.sv
// ----------------------------------------------------------------------------
// rbsd_ctrl
// Sequencer: takes a request, then issues one chunk per free output slot.
// ----------------------------------------------------------------------------
module rbsd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  rbsd_pkg::t_dp_sts i_sts,
    output logic              o_in_stall,
    output rbsd_pkg::t_dp_cmd o_cmd
);
    import rbsd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.run_req) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_sts.out_free && i_sts.run_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            S_RUN: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

### hdl/rbsd_dpath.sv
// ----------------------------------------------------------------------------
// rbsd_dpath
// Decode state, run length clamp, chunk builder and output register.
// ----------------------------------------------------------------------------
module rbsd_dpath #(
    parameter int LANES      = rbsd_pkg::LANES_DEF,
    parameter int COUNT_BITS = rbsd_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rbsd_pkg::t_dp_cmd             i_cmd,
    output rbsd_pkg::t_dp_sts             o_sts,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_frame_start,
    input  logic [rbsd_pkg::MODE_W-1:0]   i_mode,
    input  logic [rbsd_pkg::LIMIT_W-1:0]  i_out_limit,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output rbsd_pkg::t_lanes              o_lanes,
    output logic [rbsd_pkg::CHUNK_W-1:0]  o_valid_bytes,
    output logic                          o_last,
    output logic                          o_limit_reached
);
    import rbsd_pkg::*;

    localparam int LANES_EFF = (LANES < 1) ? 1 : ((LANES > OUT_LANES) ? OUT_LANES : LANES);
    localparam int CMP_W     = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
    localparam logic [CHUNK_W-1:0] LANES_K   = CHUNK_W'(LANES_EFF);
    localparam logic [CHUNK_W-1:0] CHUNK_END = CHUNK_W'(MAX_CHUNKS - 1);

    t_phase               r_phase;
    t_phase               n_phase;
    logic [7:0]           r_lit_left;
    logic [7:0]           n_lit_left;
    logic [RUN_W-1:0]     r_rep_cnt;
    logic [RUN_W-1:0]     n_rep_cnt;
    logic [COUNT_BITS-1:0] r_bytes_wr;
    logic [COUNT_BITS-1:0] n_bytes_wr;
    logic [RUN_W-1:0]     r_run_left;
    logic [7:0]           r_run_val;
    logic [CHUNK_W-1:0]   r_chunk;
    logic                 r_out_valid;
    t_lanes               r_lanes;
    logic [CHUNK_W-1:0]   r_valid_bytes;
    logic                 r_last;
    logic                 r_limit_reached;

    t_phase               base_phase;
    logic [7:0]           base_lit;
    logic [RUN_W-1:0]     base_rep;
    logic [COUNT_BITS-1:0] base_bw;
    logic [CMP_W-1:0]     bw_ext;
    logic [CMP_W-1:0]     limit_ext;
    logic [CMP_W-1:0]     room;
    logic                 ignore;
    logic                 rle;
    logic [RUN_W-1:0]     run_n;
    logic [7:0]           run_val;
    logic [RUN_W-1:0]     run_clamp;
    logic [CHUNK_W-1:0]   chunk_k;
    logic [COUNT_BITS:0]  bw_sum;
    logic [COUNT_BITS-1:0] bw_next;

    // frame start clears the decode state ahead of the byte
    always_comb begin
        base_phase = i_frame_start ? PH_HEADER : r_phase;
        base_lit   = i_frame_start ? 8'd0 : r_lit_left;
        base_rep   = i_frame_start ? '0 : r_rep_cnt;
        base_bw    = i_frame_start ? '0 : r_bytes_wr;
    end

    assign bw_ext    = CMP_W'(base_bw);
    assign limit_ext = CMP_W'(i_out_limit);
    assign ignore    = bw_ext >= limit_ext;
    assign room      = limit_ext - bw_ext;
    assign rle       = (i_mode == MODE_REPEAT) || (i_mode == MODE_ZERO);

    always_comb begin
        n_phase    = base_phase;
        n_lit_left = base_lit;
        n_rep_cnt  = base_rep;
        run_n      = '0;
        run_val    = i_in_byte;
        if (!rle) begin
            run_n = RUN_W'(1);
        end else begin
            case (base_phase)
                PH_LITERAL: begin
                    n_lit_left = base_lit - 8'd1;
                    if (n_lit_left == 8'd0) begin
                        n_phase = PH_HEADER;
                    end
                    run_n = RUN_W'(1);
                end
                PH_VALUE: begin
                    run_n     = base_rep;
                    n_phase   = PH_HEADER;
                    n_rep_cnt = '0;
                end
                default: begin
                    n_phase = PH_HEADER;
                    if (i_in_byte == 8'd0) begin
                        run_n = '0;
                    end else if (i_in_byte <= RUN_BASE) begin
                        n_lit_left = i_in_byte;
                        n_phase    = PH_LITERAL;
                    end else if (i_mode == MODE_REPEAT) begin
                        n_rep_cnt = i_in_byte[RUN_W-1:0];
                        n_phase   = PH_VALUE;
                    end else begin
                        run_n   = i_in_byte[RUN_W-1:0];
                        run_val = 8'd0;
                    end
                end
            endcase
        end
    end

    assign run_clamp = (room < CMP_W'(run_n)) ? room[RUN_W-1:0] : run_n;

    // chunk size and saturating written count
    assign chunk_k = (r_run_left < RUN_W'(LANES_K)) ? r_run_left[CHUNK_W-1:0] : LANES_K;
    assign bw_sum  = {1'b0, r_bytes_wr} + (COUNT_BITS + 1)'(chunk_k);
    assign bw_next = bw_sum[COUNT_BITS] ? '1 : bw_sum[COUNT_BITS-1:0];

    assign o_sts.run_req  = !ignore && (run_clamp != '0);
    assign o_sts.run_done = (r_run_left == RUN_W'(chunk_k)) || (r_chunk == CHUNK_END);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign n_bytes_wr = i_cmd.emit ? bw_next : base_bw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_lit_left  <= '0;
            r_rep_cnt   <= '0;
            r_bytes_wr  <= '0;
            r_run_left  <= '0;
            r_chunk     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_bytes_wr <= n_bytes_wr;
                r_chunk    <= '0;
                if (ignore) begin
                    r_phase    <= base_phase;
                    r_lit_left <= base_lit;
                    r_rep_cnt  <= base_rep;
                    r_run_left <= '0;
                end else begin
                    r_phase    <= n_phase;
                    r_lit_left <= n_lit_left;
                    r_rep_cnt  <= n_rep_cnt;
                    r_run_left <= run_clamp;
                end
            end else if (i_cmd.emit) begin
                r_bytes_wr <= n_bytes_wr;
                r_run_left <= r_run_left - RUN_W'(chunk_k);
                r_chunk    <= r_chunk + CHUNK_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_run_val <= run_val;
        end
        if (i_cmd.emit) begin
            for (int j = 0; j < OUT_LANES; j++) begin
                r_lanes[j] <= (CHUNK_W'(j) < chunk_k) ? r_run_val : 8'd0;
            end
            r_valid_bytes   <= chunk_k;
            r_last          <= r_run_left == RUN_W'(chunk_k);
            r_limit_reached <= CMP_W'(bw_next) >= limit_ext;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_lanes         = r_lanes;
    assign o_valid_bytes   = r_valid_bytes;
    assign o_last          = r_last;
    assign o_limit_reached = r_limit_reached;

endmodule

### hdl/rle_byte_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// rle_byte_stream_decoder_core
// Run-length byte stream decoder: pass-through, repeat and zero-fill modes,
// output in chunks of up to eight bytes, cut at a programmable byte limit.
//
//   channel   handshake                  payload
//   input     i_in_valid / o_in_stall    i_in_byte, i_frame_start
//   output    o_out_valid / i_out_stall  o_lane0..7, o_valid_bytes, o_last,
//                                        o_limit_reached
//   config    APB psel/penable/pready    paddr, pwdata, prdata
//
// a request is taken, then the chunk sequencer issues its chunks one per free
// output slot: ceil(run / lanes) chunks, at most MAX_CHUNKS per request
// a request with no output (header, ignored byte) does not enter the sequencer
// synchronous active-low reset, no clearing pass
// output stalls hold the chunk sequencer, input is stalled until a run ends
// ----------------------------------------------------------------------------
module rle_byte_stream_decoder_core #(
    parameter int LANES      = rbsd_pkg::LANES_DEF,
    parameter int COUNT_BITS = rbsd_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_frame_start,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_lane0,
    output logic [7:0]                    o_lane1,
    output logic [7:0]                    o_lane2,
    output logic [7:0]                    o_lane3,
    output logic [7:0]                    o_lane4,
    output logic [7:0]                    o_lane5,
    output logic [7:0]                    o_lane6,
    output logic [7:0]                    o_lane7,
    output logic [rbsd_pkg::CHUNK_W-1:0]  o_valid_bytes,
    output logic                          o_last,
    output logic                          o_limit_reached,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbsd_pkg::APB_AW-1:0]   paddr,
    input  logic [rbsd_pkg::APB_DW-1:0]   pwdata,
    output logic [rbsd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import rbsd_pkg::*;

    localparam int LANES_EFF = (LANES < 1) ? 1 : ((LANES > OUT_LANES) ? OUT_LANES : LANES);

    logic [MODE_W-1:0]  r_mode;
    logic [LIMIT_W-1:0] r_out_limit;
    logic               cfg_wr;
    t_dp_cmd            cmd;
    t_dp_sts            sts;
    t_lanes             lanes;
    logic               chunk_size_ok;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_PASS;
            r_out_limit <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_MODE:  r_mode      <= pwdata[MODE_W-1:0];
                REG_LIMIT: r_out_limit <= pwdata[LIMIT_W-1:0];
                default:   r_mode      <= r_mode;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MODE:  prdata = APB_DW'(r_mode);
            REG_LIMIT: prdata = APB_DW'(r_out_limit);
            default:   prdata = '0;
        endcase
    end

    rbsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    rbsd_dpath #(
        .LANES      (LANES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_in_byte       (i_in_byte),
        .i_frame_start   (i_frame_start),
        .i_mode          (r_mode),
        .i_out_limit     (r_out_limit),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_lanes         (lanes),
        .o_valid_bytes   (o_valid_bytes),
        .o_last          (o_last),
        .o_limit_reached (o_limit_reached)
    );

    assign o_lane0 = lanes[0];
    assign o_lane1 = lanes[1];
    assign o_lane2 = lanes[2];
    assign o_lane3 = lanes[3];
    assign o_lane4 = lanes[4];
    assign o_lane5 = lanes[5];
    assign o_lane6 = lanes[6];
    assign o_lane7 = lanes[7];

    assign chunk_size_ok = (o_valid_bytes != '0) && (o_valid_bytes <= CHUNK_W'(LANES_EFF));

`include "assert_macros.svh"

    `ASSERT_NEVER(a_accept_during_run, i_clk, i_rst_n, cmd.accept && cmd.emit)
    `ASSERT_ALWAYS(a_chunk_size, i_clk, i_rst_n, o_out_valid |-> chunk_size_ok)
    `ASSERT_ALWAYS(a_limit_ends_run, i_clk, i_rst_n, (o_out_valid && o_limit_reached) |-> o_last)

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the run-length byte stream decoder. A behavioral
// decoder predicts every output chunk from each accepted request and a
// monitor compares chunks in order. Directed tests cover pass-through,
// literal, repeat and zero-fill decoding, the byte limit and mode switches;
// then an output hold and random well-formed streams with noise, with APB
// register writes with readback; both channels idle at random, not in the last streams.
// ----------------------------------------------------------------------------
module testbench;
    import rbsd_pkg::*;

    localparam int          COUNT_MAX  = (1 << COUNT_BITS_DEF) - 1;
    localparam logic [2:0]  ADDR_MODE  = {REG_MODE, 2'b00};
    localparam logic [2:0]  ADDR_LIMIT = {REG_LIMIT, 2'b00};

    typedef struct packed {
        t_lanes     lanes;
        logic [3:0] nbytes;
        logic       last;
        logic       at_limit;
    } t_chunk;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [7:0]           i_in_byte;
    logic                 i_frame_start;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [7:0]           o_lane0, o_lane1, o_lane2, o_lane3;
    logic [7:0]           o_lane4, o_lane5, o_lane6, o_lane7;
    logic [CHUNK_W-1:0]   o_valid_bytes;
    logic                 o_last;
    logic                 o_limit_reached;
    logic                 psel, penable, pwrite, pready;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata, prdata;

    // decoder prediction state
    logic [MODE_W-1:0]    cur_mode    = MODE_PASS;
    logic [LIMIT_W-1:0]   cur_limit   = '0;
    t_phase               pred_phase  = PH_HEADER;
    logic [7:0]           lit_left    = '0;
    logic [RUN_W-1:0]     run_len     = '0;
    logic [15:0]          pred_written = '0;
    t_chunk               exp_chunks[$];

    int     err_count    = 0;
    int     taken_count  = 0;
    int     useful_count = 0;
    int     chunk_count  = 0;
    int     write_count  = 0;
    bit     idle_on      = 1'b1;
    int     hold_left    = 0;
    int     stall_left   = 0;
    t_chunk got_chunk, want_chunk;

    rle_byte_stream_decoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_frame_start   (i_frame_start),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_lane0         (o_lane0),
        .o_lane1         (o_lane1),
        .o_lane2         (o_lane2),
        .o_lane3         (o_lane3),
        .o_lane4         (o_lane4),
        .o_lane5         (o_lane5),
        .o_lane6         (o_lane6),
        .o_lane7         (o_lane7),
        .o_valid_bytes   (o_valid_bytes),
        .o_last          (o_last),
        .o_limit_reached (o_limit_reached),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR: %s", msg);
    endfunction

    function automatic void push_run(input logic [7:0] value, input int unsigned count);
        int unsigned room;
        int unsigned n;
        int unsigned k;
        int          res;
        t_chunk      c;
        n    = count;
        room = (cur_limit > pred_written) ? 32'(cur_limit - pred_written) : 0;
        if (n > room) n = room;
        res = 0;
        while (n > 0 && res < MAX_CHUNKS) begin
            k = (n < OUT_LANES) ? n : OUT_LANES;
            c = '0;
            for (int j = 0; j < OUT_LANES; j++) begin
                if (j < k) c.lanes[j] = value;
            end
            if (pred_written + k > COUNT_MAX) pred_written = COUNT_MAX[15:0];
            else pred_written = pred_written + k[15:0];
            n -= k;
            c.nbytes   = 4'(k);
            c.last     = (n == 0);
            c.at_limit = (pred_written >= cur_limit);
            exp_chunks.push_back(c);
            res++;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic fs);
        int unsigned n;
        if (fs) begin
            pred_phase   = PH_HEADER;
            lit_left     = '0;
            run_len      = '0;
            pred_written = '0;
        end
        if (pred_written >= cur_limit) return;
        useful_count++;
        if (cur_mode != MODE_REPEAT && cur_mode != MODE_ZERO) begin
            push_run(b, 1);
            return;
        end
        case (pred_phase)
            PH_LITERAL: begin
                lit_left = lit_left - 8'd1;
                if (lit_left == 8'd0) pred_phase = PH_HEADER;
                push_run(b, 1);
            end
            PH_VALUE: begin
                n          = 32'(run_len);
                pred_phase = PH_HEADER;
                run_len    = '0;
                push_run(b, n);
            end
            default: begin
                pred_phase = PH_HEADER;
                if (b == 8'd0) begin
                end else if (b <= RUN_BASE) begin
                    lit_left   = b;
                    pred_phase = PH_LITERAL;
                end else if (cur_mode == MODE_REPEAT) begin
                    run_len    = RUN_W'(b - RUN_BASE);
                    pred_phase = PH_VALUE;
                end else begin
                    push_run(8'd0, 32'(b - RUN_BASE));
                end
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fs);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_byte     <= b;
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_in_stall);
        taken_count++;
        decode_byte(b, fs);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (exp_chunks.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic reg_access(input logic [2:0] addr, input logic [31:0] data);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        write_count++;
        if (addr == ADDR_MODE) cur_mode = data[MODE_W-1:0];
        else cur_limit = data[LIMIT_W-1:0];
        want = (addr == ADDR_MODE) ? 32'(cur_mode) : 32'(cur_limit);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want)
            note_error($sformatf("readback at %0d: expected %h, got %h", addr, want, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] m, input logic [15:0] lim);
        wait_idle();
        reg_access(ADDR_MODE, 32'(m));
        reg_access(ADDR_LIMIT, 32'(lim));
    endtask

    task automatic send_packet();
        int          n;
        logic [7:0]  hdr;
        logic        fs;
        fs = (pred_written >= cur_limit) || ($urandom_range(0, 11) == 0);
        if (cur_mode == MODE_REPEAT || cur_mode == MODE_ZERO) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40)
                                                     : $urandom_range(1, 8);
                    send_byte(8'(n), fs);
                    repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                5, 6, 7, 8: begin
                    hdr = $urandom_range(0, 1) ? 8'($urandom_range(129, 255))
                                               : 8'($urandom_range(129, 140));
                    send_byte(hdr, fs);
                    if (cur_mode == MODE_REPEAT)
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                default: send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            endcase
        end else begin
            send_byte(8'($urandom_range(0, 255)), fs);
        end
    endtask

    task automatic test_pass_through();
        set_config(MODE_PASS, 16'hFFFF);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        set_config(2'd3, 16'hFFFF);
        send_byte(8'hA5, 1'b0);
    endtask

    task automatic test_literal_and_repeat();
        set_config(MODE_REPEAT, 16'hFFFF);
        send_byte(8'h00, 1'b1);
        send_byte(8'h02, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'hED, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h81, 1'b1);
        send_byte(8'h7E, 1'b0);
    endtask

    task automatic test_zero_fill();
        set_config(MODE_ZERO, 16'hFFFF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h89, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hC3, 1'b0);
    endtask

    task automatic test_limit_cut();
        set_config(MODE_PASS, 16'h0000);
        send_byte(8'h11, 1'b1);
        set_config(MODE_ZERO, 16'd5);
        send_byte(8'h94, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h83, 1'b1);
    endtask

    task automatic test_mode_switch();
        set_config(MODE_REPEAT, 16'hFFFF);
        send_byte(8'h85, 1'b1);
        set_config(MODE_ZERO, 16'hFFFF);
        send_byte(8'h99, 1'b0);
        send_byte(8'h02, 1'b0);
        set_config(MODE_REPEAT, 16'hFFFF);
        send_byte(8'h44, 1'b0);
        send_byte(8'hBB, 1'b0);
    endtask

    task automatic test_output_hold();
        set_config(MODE_REPEAT, 16'hFFFF);
        hold_left = 400;
        for (int i = 0; i < 8; i++) begin
            send_byte(8'($urandom_range(129, 255)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic test_random_streams();
        int         base;
        int         phase_start;
        logic [1:0] m;
        logic [15:0] lim;
        base = useful_count;
        while (useful_count - base < 110) begin
            if (useful_count - base >= 80) idle_on = 1'b0;
            case ($urandom_range(0, 5))
                0:       m = MODE_PASS;
                1:       m = 2'd3;
                2, 3:    m = MODE_REPEAT;
                default: m = MODE_ZERO;
            endcase
            case ($urandom_range(0, 3))
                0:       lim = 16'($urandom_range(1, 48));
                1:       lim = 16'($urandom_range(49, 65534));
                default: lim = 16'hFFFF;
            endcase
            set_config(m, lim);
            phase_start = useful_count;
            while (useful_count - phase_start < 25 && useful_count - base < 110)
                send_packet();
        end
    endtask

    // output side idling and long hold
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 16);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_chunk.lanes    = {o_lane7, o_lane6, o_lane5, o_lane4,
                                  o_lane3, o_lane2, o_lane1, o_lane0};
            got_chunk.nbytes   = o_valid_bytes;
            got_chunk.last     = o_last;
            got_chunk.at_limit = o_limit_reached;
            chunk_count++;
            if (exp_chunks.size() == 0) begin
                note_error($sformatf("unexpected chunk lanes %h bytes %0d last %b limit %b",
                                     got_chunk.lanes, got_chunk.nbytes,
                                     got_chunk.last, got_chunk.at_limit));
            end else begin
                want_chunk = exp_chunks.pop_front();
                if (got_chunk.lanes !== want_chunk.lanes ||
                    got_chunk.nbytes !== want_chunk.nbytes ||
                    got_chunk.last !== want_chunk.last ||
                    got_chunk.at_limit !== want_chunk.at_limit)
                    note_error($sformatf(
                        "chunk %0d: expected lanes %h bytes %0d last %b limit %b, got lanes %h bytes %0d last %b limit %b",
                        chunk_count, want_chunk.lanes, want_chunk.nbytes,
                        want_chunk.last, want_chunk.at_limit, got_chunk.lanes,
                        got_chunk.nbytes, got_chunk.last, got_chunk.at_limit));
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in_byte     <= '0;
        i_frame_start <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_pass_through();
        test_literal_and_repeat();
        test_zero_fill();
        test_limit_cut();
        test_mode_switch();
        test_output_hold();
        test_random_streams();
        wait_idle();
        $display("covered pass-through, repeat and zero-fill decoding, limit cuts, mode switches");
        $display("%0d requests taken, %0d chunks checked, %0d register writes",
                 taken_count, chunk_count, write_count);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/rbsd_pkg.sv
hdl/rbsd_ctrl.sv
hdl/rbsd_dpath.sv
hdl/rle_byte_stream_decoder_core.sv
tb/testbench.sv
